@@ hdl/ease_in_out_distance_profile_defines.svh @@
// ----------------------------------------------------------------------------
// Ease-in/ease-out distance profile: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef EASE_IN_OUT_DISTANCE_PROFILE_DEFINES_SVH
`define EASE_IN_OUT_DISTANCE_PROFILE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define EIDP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define EIDP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/eidp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ease-in/ease-out distance profile: package
// Q30 constants, register indexes, region codes, the per-item context, sine coefficients and a Q30 multiply.
// ----------------------------------------------------------------------------
package eidp_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int Q_BITS = 30;

    localparam logic [30:0] Q_ONE       = 31'h4000_0000;
    localparam logic [30:0] TWO_OVER_PI = 31'd683565276;

    localparam logic [1:0] CFG_ACCEL_END    = 2'd0;
    localparam logic [1:0] CFG_DECEL_START  = 2'd1;
    localparam logic [1:0] CFG_PROFILE_MODE = 2'd2;

    localparam logic [1:0] REGION_LO  = 2'd0;
    localparam logic [1:0] REGION_MID = 2'd1;
    localparam logic [1:0] REGION_HI  = 2'd2;

    typedef struct packed {
        logic [30:0] tq;
        logic [30:0] k1q;
        logic [30:0] k2q;
        logic [29:0] a;
        logic [29:0] b;
        logic [1:0]  region;
        logic        mode;
        logic        err;
    } ctx_t;

    function automatic logic [30:0] sin_coef(input logic [2:0] idx);
        logic [30:0] c;
        case (idx)
            3'd0:    c = 31'd1686629713;
            3'd1:    c = 31'd693598668;
            3'd2:    c = 31'd85569306;
            3'd3:    c = 31'd5026996;
            3'd4:    c = 31'd172272;
            3'd5:    c = 31'd3864;
            default: c = '0;
        endcase
        return c;
    endfunction

    function automatic logic [31:0] mul30(input logic [30:0] x, input logic [30:0] y);
        logic [61:0] p;
        p = 62'(x) * 62'(y);
        return p[61:30];
    endfunction

endpackage

@@ hdl/eidp_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ease-in/ease-out distance profile: pipelined divider
// Restoring division, one quotient bit per register stage, with sideband.
// ----------------------------------------------------------------------------
module eidp_div #(
    parameter int QB = 30,
    parameter int DW = 31,
    parameter int SW = 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_vld,
    input  logic [QB+DW-1:0]     in_num,
    input  logic [DW-1:0]        in_den,
    input  logic [SW-1:0]        in_side,
    output logic                 out_vld,
    output logic [QB-1:0]        out_quo,
    output logic [SW-1:0]        out_side
);

    logic          vld_reg  [QB];
    logic [DW-1:0] rem_reg  [QB];
    logic [QB-1:0] low_reg  [QB];
    logic [QB-1:0] quo_reg  [QB];
    logic [DW-1:0] den_reg  [QB];
    logic [SW-1:0] side_reg [QB];

    genvar g;
    generate
        for (g = 0; g < QB; g++)
        begin : g_stage
            logic          vld_in;
            logic [DW-1:0] rem_in;
            logic [DW-1:0] den_in;
            logic [QB-1:0] low_in;
            logic [QB-1:0] quo_in;
            logic [SW-1:0] side_in;
            logic [DW:0]   trial;
            logic          take;
            logic [DW-1:0] rem_next;

            if (g == 0)
            begin : g_head
                assign vld_in  = in_vld;
                assign rem_in  = in_num[QB+DW-1:QB];
                assign low_in  = in_num[QB-1:0];
                assign quo_in  = '0;
                assign den_in  = in_den;
                assign side_in = in_side;
            end
            else
            begin : g_body
                assign vld_in  = vld_reg[g-1];
                assign rem_in  = rem_reg[g-1];
                assign low_in  = low_reg[g-1];
                assign quo_in  = quo_reg[g-1];
                assign den_in  = den_reg[g-1];
                assign side_in = side_reg[g-1];
            end

            assign trial    = {rem_in, low_in[QB-1]};
            assign take     = trial >= {1'b0, den_in};
            assign rem_next = take ? DW'(trial - {1'b0, den_in}) : DW'(trial);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[g] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[g] <= vld_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[g]  <= rem_next;
                    low_reg[g]  <= low_in << 1;
                    quo_reg[g]  <= (quo_in << 1) | QB'(take);
                    den_reg[g]  <= den_in;
                    side_reg[g] <= side_in;
                end
            end
        end
    endgenerate

    assign out_vld  = vld_reg[QB-1];
    assign out_quo  = quo_reg[QB-1];
    assign out_side = side_reg[QB-1];

endmodule

@@ hdl/ease_in_out_distance_profile.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ease-in/ease-out distance profile
// Maps a normalized time to normalized distance with a sinusoidal or a
// parabolic speed profile, one beat per clock while the skid stage is empty.
// ----------------------------------------------------------------------------
// The block accepts one beat every clock while the skid stage is empty and
// returns one result beat per input beat, in order; the latency is set by
// the two restoring dividers, which resolve one quotient bit per pipeline
// stage, and by the five-stage sine polynomial between them. An output
// register with a skid stage lets input beats be taken while a result waits,
// until the skid stage fills. Configuration registers must only be written
// while no beat is in flight.
// ----------------------------------------------------------------------------
`include "ease_in_out_distance_profile_defines.svh"

module ease_in_out_distance_profile
    import eidp_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [1:0]                            cfg_index,
    input  logic [FRAC_BITS:0]                    cfg_wdata,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // time_fraction
    input  logic [((FRAC_BITS+8)/8)*8-1:0]        s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // distance_fraction
    output logic [((FRAC_BITS+8)/8)*8-1:0]        m_axis_tdata,
    // config_error
    output logic                                  m_axis_tuser
);

    localparam int FW  = FRAC_BITS + 1;
    localparam int SH  = Q_BITS - FRAC_BITS;
    localparam int TDW = ((FW + 7) / 8) * 8;
    localparam int QB1 = Q_BITS + 1;
    localparam int QB2 = FRAC_BITS + 2;
    localparam int N2W = QB2 + 32;
    localparam logic [FW-1:0] FX_ONE = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [FW-1:0] K1_RST = FW'((longint'(13107) << FRAC_BITS) >> 16);
    localparam logic [FW-1:0] K2_RST = FW'((longint'(52429) << FRAC_BITS) >> 16);

    logic          en;

    logic [FW-1:0] k1_reg;
    logic [FW-1:0] k2_reg;
    logic          mode_reg;

    logic          s1_vld_reg;
    logic [FW-1:0] s1_t_reg;
    logic [FW-1:0] s1_k1_reg;
    logic [FW-1:0] s1_k2_reg;
    logic          s1_mode_reg;

    logic [FW-1:0] t_c;
    logic [FW-1:0] k1_c;
    logic [FW-1:0] k2_c;
    logic [30:0]   sq_base;
    ctx_t          s2_ctx_next;
    logic [59:0]   s2_sq_next;

    logic          s2_vld_reg;
    ctx_t          s2_ctx_reg;
    logic [59:0]   s2_sq_reg;

    logic [61:0]   d1_num;
    logic [30:0]   d1_den;
    logic          d1_vld;
    logic [30:0]   d1_quo;
    logic [$bits(ctx_t)-1:0] d1_side;
    ctx_t          d1_ctx;

    logic [30:0]   s4_arg_next;
    logic          s4_vld_reg;
    ctx_t          s4_ctx_reg;
    logic [30:0]   s4_quo_reg;
    logic [30:0]   s4_arg_reg;
    logic [30:0]   s4_x2_reg;

    logic          h_vld_reg [5];
    ctx_t          h_ctx_reg [5];
    logic [30:0]   h_quo_reg [5];
    logic [30:0]   h_arg_reg [5];
    logic [30:0]   h_x2_reg  [5];
    logic [30:0]   h_acc_reg [5];

    logic [31:0]   s_full;
    logic          s10_vld_reg;
    ctx_t          s10_ctx_reg;
    logic [30:0]   s10_quo_reg;
    logic [30:0]   s10_s_reg;

    logic [29:0]   s11_prod_next;
    logic [31:0]   s11_den_next;
    logic          s11_vld_reg;
    ctx_t          s11_ctx_reg;
    logic [30:0]   s11_quo_reg;
    logic [29:0]   s11_prod_reg;
    logic [31:0]   s11_den_reg;

    logic [31:0]   num_c;
    logic          s12_vld_reg;
    logic          s12_err_reg;
    logic [N2W-1:0] s12_num_reg;
    logic [31:0]   s12_den_reg;

    logic          d2_vld;
    logic [QB2-1:0] d2_quo;
    logic [0:0]    d2_side;
    logic [FW-1:0] pipe_dist;

    logic          out_vld_reg;
    logic [FW-1:0] out_dist_reg;
    logic          out_err_reg;
    logic          skid_vld_reg;
    logic [FW-1:0] skid_dist_reg;
    logic          skid_err_reg;

    assign en            = !skid_vld_reg;
    assign s_axis_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k1_reg   <= K1_RST;
            k2_reg   <= K2_RST;
            mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ACCEL_END:    k1_reg   <= cfg_wdata;
                CFG_DECEL_START:  k2_reg   <= cfg_wdata;
                CFG_PROFILE_MODE: mode_reg <= cfg_wdata[0];
                default:          ;
            endcase
        end
    end

    // Stage 1: input capture.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_t_reg    <= s_axis_tdata[FW-1:0];
            s1_k1_reg   <= k1_reg;
            s1_k2_reg   <= k2_reg;
            s1_mode_reg <= mode_reg;
        end
    end

    // Stage 2: saturation, Q30 scaling, region, square and segment gains.
    always_comb
    begin
        t_c  = (s1_t_reg  > FX_ONE) ? FX_ONE : s1_t_reg;
        k1_c = (s1_k1_reg > FX_ONE) ? FX_ONE : s1_k1_reg;
        k2_c = (s1_k2_reg > FX_ONE) ? FX_ONE : s1_k2_reg;
        s2_ctx_next.err  = s1_k1_reg > s1_k2_reg;
        s2_ctx_next.mode = s1_mode_reg;
        s2_ctx_next.tq   = 31'(t_c)  << SH;
        s2_ctx_next.k1q  = 31'(k1_c) << SH;
        s2_ctx_next.k2q  = 31'(k2_c) << SH;
        if (s2_ctx_next.tq < s2_ctx_next.k1q)
        begin
            s2_ctx_next.region = REGION_LO;
        end
        else if (s2_ctx_next.tq > s2_ctx_next.k2q)
        begin
            s2_ctx_next.region = REGION_HI;
        end
        else
        begin
            s2_ctx_next.region = REGION_MID;
        end
        sq_base = (s2_ctx_next.region == REGION_LO) ? s2_ctx_next.tq
                                                    : s2_ctx_next.tq - s2_ctx_next.k2q;
        s2_sq_next    = 60'(62'(sq_base) * 62'(sq_base));
        s2_ctx_next.a = 30'(mul30(s2_ctx_next.k1q, TWO_OVER_PI));
        s2_ctx_next.b = 30'(mul30(Q_ONE - s2_ctx_next.k2q, TWO_OVER_PI));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_ctx_reg <= s2_ctx_next;
            s2_sq_reg  <= s2_sq_next;
        end
    end

    // Segment fraction (sine mode) or scaled square (parabolic mode).
    // In sine mode the quotient reaches exactly 1.0 at the end of the last segment.
    always_comb
    begin
        d1_num = '0;
        d1_den = 31'd1;
        if (!s2_ctx_reg.err)
        begin
            if (s2_ctx_reg.region == REGION_LO)
            begin
                d1_den = s2_ctx_reg.k1q;
                d1_num = s2_ctx_reg.mode ? 62'(s2_sq_reg) : 62'(s2_ctx_reg.tq) << Q_BITS;
            end
            else if (s2_ctx_reg.region == REGION_HI)
            begin
                d1_den = Q_ONE - s2_ctx_reg.k2q;
                d1_num = s2_ctx_reg.mode ? 62'(s2_sq_reg)
                                         : 62'(s2_ctx_reg.tq - s2_ctx_reg.k2q) << Q_BITS;
            end
        end
    end

    eidp_div #(
        .QB (QB1),
        .DW (31),
        .SW ($bits(ctx_t))
    ) u_div_seg (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (s2_vld_reg),
        .in_num   (d1_num),
        .in_den   (d1_den),
        .in_side  (s2_ctx_reg),
        .out_vld  (d1_vld),
        .out_quo  (d1_quo),
        .out_side (d1_side)
    );

    assign d1_ctx = ctx_t'(d1_side);

    // Sine argument and its square.
    assign s4_arg_next = (d1_ctx.region == REGION_LO) ? Q_ONE - d1_quo : d1_quo;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s4_vld_reg <= d1_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_ctx_reg <= d1_ctx;
            s4_quo_reg <= d1_quo;
            s4_arg_reg <= s4_arg_next;
            s4_x2_reg  <= 31'(mul30(s4_arg_next, s4_arg_next));
        end
    end

    // Odd sine polynomial in Horner form, one coefficient per stage.
    genvar g;
    generate
        for (g = 0; g < 5; g++)
        begin : g_horner
            logic        vld_in;
            ctx_t        ctx_in;
            logic [30:0] quo_in;
            logic [30:0] arg_in;
            logic [30:0] x2_in;
            logic [30:0] acc_in;
            logic [30:0] acc_next;

            if (g == 0)
            begin : g_head
                assign vld_in = s4_vld_reg;
                assign ctx_in = s4_ctx_reg;
                assign quo_in = s4_quo_reg;
                assign arg_in = s4_arg_reg;
                assign x2_in  = s4_x2_reg;
                assign acc_in = sin_coef(3'd5);
            end
            else
            begin : g_body
                assign vld_in = h_vld_reg[g-1];
                assign ctx_in = h_ctx_reg[g-1];
                assign quo_in = h_quo_reg[g-1];
                assign arg_in = h_arg_reg[g-1];
                assign x2_in  = h_x2_reg[g-1];
                assign acc_in = h_acc_reg[g-1];
            end

            assign acc_next = sin_coef(3'(4 - g)) - 31'(mul30(x2_in, acc_in));

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    h_vld_reg[g] <= 1'b0;
                end
                else if (en)
                begin
                    h_vld_reg[g] <= vld_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    h_ctx_reg[g] <= ctx_in;
                    h_quo_reg[g] <= quo_in;
                    h_arg_reg[g] <= arg_in;
                    h_x2_reg[g]  <= x2_in;
                    h_acc_reg[g] <= acc_next;
                end
            end
        end
    endgenerate

    assign s_full = mul30(h_arg_reg[4], h_acc_reg[4]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s10_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s10_vld_reg <= h_vld_reg[4];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s10_ctx_reg <= h_ctx_reg[4];
            s10_quo_reg <= h_quo_reg[4];
            s10_s_reg   <= (s_full > 32'(Q_ONE)) ? Q_ONE : 31'(s_full);
        end
    end

    // Scaled sine term and the normalizer.
    always_comb
    begin
        if (s10_ctx_reg.region == REGION_LO)
        begin
            s11_prod_next = 30'(mul30(31'(s10_ctx_reg.a), Q_ONE - s10_s_reg));
        end
        else
        begin
            s11_prod_next = 30'(mul30(31'(s10_ctx_reg.b), s10_s_reg));
        end
        if (!s10_ctx_reg.mode)
        begin
            s11_den_next = 32'(s10_ctx_reg.a) + 32'(s10_ctx_reg.b)
                         + 32'(s10_ctx_reg.k2q) - 32'(s10_ctx_reg.k1q);
        end
        else
        begin
            s11_den_next = 32'(Q_ONE) + 32'(s10_ctx_reg.k2q) - 32'(s10_ctx_reg.k1q);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s11_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s11_vld_reg <= s10_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s11_ctx_reg  <= s10_ctx_reg;
            s11_quo_reg  <= s10_quo_reg;
            s11_prod_reg <= s11_prod_next;
            s11_den_reg  <= s11_den_next;
        end
    end

    // Distance numerator for the current segment.
    always_comb
    begin
        if (!s11_ctx_reg.mode)
        begin
            if (s11_ctx_reg.region == REGION_LO)
            begin
                num_c = 32'(s11_prod_reg);
            end
            else if (s11_ctx_reg.region == REGION_HI)
            begin
                num_c = 32'(s11_ctx_reg.a) + 32'(s11_ctx_reg.k2q) - 32'(s11_ctx_reg.k1q)
                      + 32'(s11_prod_reg);
            end
            else
            begin
                num_c = 32'(s11_ctx_reg.a) + 32'(s11_ctx_reg.tq) - 32'(s11_ctx_reg.k1q);
            end
        end
        else
        begin
            if (s11_ctx_reg.region == REGION_LO)
            begin
                num_c = 32'(s11_quo_reg);
            end
            else if (s11_ctx_reg.region == REGION_HI)
            begin
                num_c = (32'(s11_ctx_reg.tq) << 1) - 32'(s11_ctx_reg.k1q)
                      - 32'(s11_quo_reg);
            end
            else
            begin
                num_c = (32'(s11_ctx_reg.tq) << 1) - 32'(s11_ctx_reg.k1q);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s12_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s12_vld_reg <= s11_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s12_err_reg <= s11_ctx_reg.err || (s11_den_reg == '0);
            s12_num_reg <= (N2W'(num_c) << FRAC_BITS) + N2W'(s11_den_reg >> 1);
            s12_den_reg <= s11_den_reg;
        end
    end

    eidp_div #(
        .QB (QB2),
        .DW (32),
        .SW (1)
    ) u_div_norm (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (s12_vld_reg),
        .in_num   (s12_num_reg),
        .in_den   (s12_den_reg),
        .in_side  (s12_err_reg),
        .out_vld  (d2_vld),
        .out_quo  (d2_quo),
        .out_side (d2_side)
    );

    assign pipe_dist = d2_side[0] ? '0 :
                       (d2_quo > QB2'(FX_ONE)) ? FX_ONE : FW'(d2_quo);

    // Output register with skid stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg   <= 1'b0;
            out_dist_reg  <= '0;
            out_err_reg   <= 1'b0;
            skid_vld_reg  <= 1'b0;
            skid_dist_reg <= '0;
            skid_err_reg  <= 1'b0;
        end
        else if (!out_vld_reg || m_axis_tready)
        begin
            if (skid_vld_reg)
            begin
                out_vld_reg  <= 1'b1;
                out_dist_reg <= skid_dist_reg;
                out_err_reg  <= skid_err_reg;
                skid_vld_reg <= 1'b0;
            end
            else
            begin
                out_vld_reg  <= d2_vld;
                out_dist_reg <= pipe_dist;
                out_err_reg  <= d2_side[0];
            end
        end
        else if (d2_vld && en)
        begin
            skid_vld_reg  <= 1'b1;
            skid_dist_reg <= pipe_dist;
            skid_err_reg  <= d2_side[0];
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = TDW'(out_dist_reg);
    assign m_axis_tuser  = out_err_reg;

    `EIDP_ASSERT_IMP(a_err_forces_zero, out_vld_reg && out_err_reg, out_dist_reg == '0, "error beat carries nonzero distance")
    `EIDP_ASSERT_IMP(a_dist_in_range, out_vld_reg, out_dist_reg <= FX_ONE, "distance above one")
    `EIDP_ASSERT_IMP(a_skid_needs_out, skid_vld_reg, out_vld_reg, "skid full while output empty")
    `EIDP_ASSERT_IMP(a_skid_fill, $rose(skid_vld_reg), $past(out_vld_reg && !m_axis_tready), "skid filled without stall")
    `EIDP_ASSERT_NXT(a_skid_drain, skid_vld_reg && m_axis_tready, !skid_vld_reg, "skid did not drain")

endmodule

@@ tb/tb_ease_in_out_distance_profile.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the ease-in/ease-out distance profile
// Drives normalized time beats through several register settings in both
// profile modes. Each beat's distance and error flag are predicted at
// acceptance and checked in order against the result stream, with random
// idling on both sides, one long receiver stall and one gap-free phase.
// ----------------------------------------------------------------------------
module tb_ease_in_out_distance_profile;
    import eidp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam longint unsigned QONE = 64'd1 << 30;
    localparam longint unsigned FXONE = 64'd65536;
    localparam longint unsigned HALF_PI_INV = 64'd683565276;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = CFG_ACCEL_END;
    logic [16:0] cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tuser;

    logic [16:0] times_pending[$];
    logic [17:0] distances_due[$];
    logic [16:0] k1_reg = 17'd13107;
    logic [16:0] k2_reg = 17'd52429;
    logic        mode_reg = 1'b0;
    logic        steady = 1'b0;
    int          errors = 0;
    int          results_seen = 0;
    int          error_results = 0;
    int          stall_left = 0;
    bit          stall_done = 1'b0;
    int          cycles = 0;

    ease_in_out_distance_profile dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #4 clk = ~clk;

    function automatic longint unsigned q30_mul(longint unsigned x, longint unsigned y);
        return (x * y) >> 30;
    endfunction

    function automatic longint unsigned quarter_sine(longint unsigned p);
        longint unsigned sq;
        longint unsigned acc;
        if (p > QONE)
            p = QONE;
        sq = q30_mul(p, p);
        acc = 64'(sin_coef(3'd5));
        for (int i = 4; i >= 0; i--)
            acc = 64'(sin_coef(3'(i))) - q30_mul(sq, acc);
        acc = q30_mul(p, acc);
        return (acc > QONE) ? QONE : acc;
    endfunction

    function automatic longint unsigned ratio_q16(longint unsigned num, longint unsigned den);
        longint unsigned r;
        if (den == 0)
            return 0;
        r = (num * FXONE + den / 2) / den;
        return (r > FXONE) ? FXONE : r;
    endfunction

    // Returns {config_error, distance_fraction} for one time beat.
    function automatic logic [17:0] distance_for(logic [16:0] t_in);
        longint unsigned t, k1, k2, a, b, num, u, d;
        if (k1_reg > k2_reg)
            return {1'b1, 17'd0};
        t = (t_in > 17'd65536) ? FXONE : 64'(t_in);
        k1 = (k1_reg > 17'd65536) ? FXONE : 64'(k1_reg);
        k2 = (k2_reg > 17'd65536) ? FXONE : 64'(k2_reg);
        t = t << 14;
        k1 = k1 << 14;
        k2 = k2 << 14;
        if (!mode_reg)
        begin
            a = q30_mul(k1, HALF_PI_INV);
            b = q30_mul(QONE - k2, HALF_PI_INV);
            if (t < k1)
            begin
                u = (t << 30) / k1;
                num = q30_mul(a, QONE - quarter_sine(QONE - u));
            end
            else if (t > k2)
            begin
                u = ((t - k2) << 30) / (QONE - k2);
                num = a + (k2 - k1) + q30_mul(b, quarter_sine(u));
            end
            else
                num = a + (t - k1);
            return {1'b0, 17'(ratio_q16(num, a + (k2 - k1) + b))};
        end
        if (t < k1)
            num = (t * t) / k1;
        else if (t > k2)
        begin
            d = t - k2;
            num = 2 * t - k1 - (d * d) / (QONE - k2);
        end
        else
            num = 2 * t - k1;
        return {1'b0, 17'(ratio_q16(num, QONE + k2 - k1))};
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                distances_due.push_back(distance_for(s_axis_tdata[16:0]));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (times_pending.size() > 0 && (steady || $urandom_range(0, 99) >= 38))
                begin
                    s_axis_tdata <= {7'd0, times_pending.pop_front()};
                    s_axis_tvalid <= 1'b1;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                logic [17:0] want;
                if (distances_due.size() == 0)
                begin
                    $display("%0t: unexpected result beat distance=%0d error=%0b", $time,
                             m_axis_tdata, m_axis_tuser);
                    errors++;
                end
                else
                begin
                    want = distances_due.pop_front();
                    if (m_axis_tdata != {7'd0, want[16:0]} || m_axis_tuser != want[17])
                    begin
                        $display("%0t: expected distance=%0d error=%0b, actual distance=%0d error=%0b",
                                 $time, want[16:0], want[17], m_axis_tdata, m_axis_tuser);
                        errors++;
                    end
                    error_results += want[17];
                end
                results_seen++;
            end
            if (results_seen == 150 && !stall_done)
            begin
                stall_done <= 1'b1;
                stall_left <= 400;
                m_axis_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= steady || $urandom_range(0, 99) >= 38;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic drain();
        while (times_pending.size() > 0 || distances_due.size() > 0 || s_axis_tvalid)
            @(posedge clk);
        repeat (70) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [16:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_ACCEL_END:   k1_reg = val;
            CFG_DECEL_START: k2_reg = val;
            default:         mode_reg = val[0];
        endcase
    endtask

    task automatic setup(logic [16:0] k1, logic [16:0] k2, logic m);
        drain();
        write_reg(CFG_ACCEL_END, k1);
        write_reg(CFG_DECEL_START, k2);
        write_reg(CFG_PROFILE_MODE, {16'd0, m});
    endtask

    task automatic queue_random(int n);
        for (int i = 0; i < n; i++)
            times_pending.push_back(($urandom_range(0, 9) == 0) ?
                17'($urandom_range(0, 131071)) : 17'($urandom_range(0, 65536)));
    endtask

    initial
    begin
        logic [16:0] r1, r2;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (r1[i]) times_pending.push_back(17'd0);
        times_pending.push_back(17'd1);
        times_pending.push_back(17'd13106);
        times_pending.push_back(17'd13107);
        times_pending.push_back(17'd52429);
        times_pending.push_back(17'd52430);
        times_pending.push_back(17'd65535);
        times_pending.push_back(17'd65536);
        times_pending.push_back(17'd65537);
        times_pending.push_back(17'd131071);
        times_pending.push_back(17'd32768);
        setup(17'd13107, 17'd52429, 1'b1);
        times_pending.push_back(17'd0);
        times_pending.push_back(17'd13107);
        times_pending.push_back(17'd65536);
        times_pending.push_back(17'd131071);
        queue_random(60);
        setup(17'd0, 17'd65536, 1'b0);
        queue_random(40);
        setup(17'd0, 17'd65536, 1'b1);
        queue_random(40);
        setup(17'd32768, 17'd32768, 1'b0);
        times_pending.push_back(17'd32768);
        queue_random(30);
        setup(17'd65536, 17'd65536, 1'b1);
        queue_random(30);
        setup(17'd0, 17'd0, 1'b0);
        queue_random(30);
        setup(17'd131071, 17'd131071, 1'b1);
        queue_random(20);
        setup(17'd70000, 17'd131071, 1'b0);
        queue_random(20);
        setup(17'd131071, 17'd0, 1'b0);
        queue_random(20);
        setup(17'd40000, 17'd20000, 1'b1);
        queue_random(20);

        setup(17'd13107, 17'd52429, 1'b0);
        steady = 1'b1;
        queue_random(100);
        drain();
        steady = 1'b0;

        for (int ph = 0; ph < 10; ph++)
        begin
            r1 = 17'($urandom_range(0, 65536));
            r2 = 17'($urandom_range(0, 65536));
            if (ph % 4 != 3 && r1 > r2)
            begin
                r1 ^= r2;
                r2 ^= r1;
                r1 ^= r2;
            end
            setup(r1, r2, ph[0]);
            queue_random(55);
        end
        drain();

        $display("Covered %0d result beats (%0d with the ordering error) over 22 settings",
                 results_seen, error_results);
        $display("of both profile modes, with a long receiver stall and a gap-free phase.");
        if (errors == 0 && distances_due.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
